// ===== hdl/rsa_pkg.sv =====
package rsa_pkg;

  // default number of fractional bits of the fixed-point datapath
  localparam int FRAC_BITS_DEF = 16;

  // saturation setting that leaves a pixel unchanged
  localparam logic [7:0] LEVEL_NEUTRAL = 8'd80;

  // register reset values
  localparam logic [7:0] LEVEL_RESET = 8'd80;
  localparam logic [7:0] SCALE_RESET = 8'd100;

  // byte limits of an output channel
  localparam logic [7:0] BYTE_MAX = 8'd255;
  localparam logic [7:0] BYTE_MIN = 8'd0;

  // color channels per pixel
  localparam int CHANNELS = 3;

  // configuration register indexes
  typedef enum logic [7:0] {
    CFG_SAT_LEVEL = 8'd0,
    CFG_INC_SCALE = 8'd1
  } cfg_reg_t;

endpackage

// ===== hdl/rgb_saturation_adjust.sv =====
// HSL saturation adjustment of an 8-bit RGB pixel stream. Pixels enter on
// s_axis (red in the lowest byte) and leave on m_axis in the same order, one
// pixel per clock while m_axis_tready is high and no increment division runs,
// through two bit-per-stage dividers (HSL saturation, then the push factor).
// Gray pixels pass unchanged. Writing saturation_level (index 0) or
// increment_scale (index 1) starts a bit-serial division of the increment;
// during it cfg_ready and s_axis_tready stay low. Write configuration only
// while no pixel is in flight.
module rgb_saturation_adjust import rsa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // fields from bit 0 up: red_in, green_in, blue_in
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0 up: red_out, green_out, blue_out
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW  = FRAC_BITS + 9;
  localparam int HW  = FRAC_BITS + 19;
  localparam int VW  = FRAC_BITS + 20;
  localparam int SQ  = FRAC_BITS + 1;
  localparam int SNW = FRAC_BITS + 8;
  localparam int PQ  = FRAC_BITS + 9;
  localparam int PNW = 2 * FRAC_BITS + 8;
  localparam int S1W = 1 + 24 + 9 + 3 + 27 + 3 * HW;
  localparam int S2W = 1 + 24 + 9 + 3 + 3 + 1 + 3 * HW;
  localparam logic signed [IW-1:0] ONE_I = {{(IW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // configuration registers and increment
  logic [7:0]           level;
  logic [7:0]           scale;
  logic                 cfg_start;
  logic                 inc_busy;
  logic                 busy_all;
  logic signed [IW-1:0] inc_q;

  assign busy_all  = inc_busy || cfg_start;
  assign cfg_ready = !busy_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= LEVEL_RESET;
      scale     <= SCALE_RESET;
      cfg_start <= 1'b0;
    end else begin
      cfg_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SAT_LEVEL: begin
            level     <= cfg_data;
            cfg_start <= 1'b1;
          end
          CFG_INC_SCALE: begin
            scale     <= cfg_data;
            cfg_start <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  rsa_inc_div #(.FRAC_BITS(FRAC_BITS)) u_inc_div (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_start),
    .level (level),
    .scale (scale),
    .busy  (inc_busy),
    .inc_q (inc_q)
  );

  // handshake chain
  logic vA, vB, vC, vD, vE, vF;
  logic rdyA, rdyB, rdyC, rdyD, rdyE, rdyF;
  logic d1_in_ready, d1_out_valid, d2_in_ready, d2_out_valid;

  assign rdyF = !vF || m_axis_tready;
  assign rdyE = !vE || d2_in_ready;
  assign rdyD = !vD || rdyE;
  assign rdyC = !vC || d1_in_ready;
  assign rdyB = !vB || rdyC;
  assign rdyA = !vA || rdyB;
  assign s_axis_tready = rdyA && !busy_all;

  // stage A: capture the pixel
  logic [2:0][7:0] pixA;
  always_ff @(posedge clk) begin
    if (rst) vA <= 1'b0;
    else if (rdyA) vA <= s_axis_tvalid && !busy_all;
  end
  always_ff @(posedge clk) begin
    if (rdyA && s_axis_tvalid && !busy_all) pixA <= s_axis_tdata;
  end

  // stage B: max, min, sum, saturation denominator, offsets from lightness
  logic [7:0]             mx, mn;
  logic [8:0]             sum_w, den_w;
  logic [2:0][7:0]        pixB;
  logic [8:0]             sumB;
  logic [7:0]             denB, spanB;
  logic signed [9:0]      dB [3];
  logic                   grayB;

  always_comb begin
    mx = pixA[0];
    mn = pixA[0];
    for (int c = 1; c < CHANNELS; c++) begin
      if (pixA[c] > mx) mx = pixA[c];
      if (pixA[c] < mn) mn = pixA[c];
    end
    sum_w = {1'b0, mx} + {1'b0, mn};
    den_w = (sum_w < 9'd255) ? sum_w : (9'd510 - sum_w);
  end

  always_ff @(posedge clk) begin
    if (rst) vB <= 1'b0;
    else if (rdyB) vB <= vA;
  end
  always_ff @(posedge clk) begin
    if (rdyB && vA) begin
      pixB  <= pixA;
      sumB  <= sum_w;
      denB  <= den_w[7:0];
      spanB <= mx - mn;
      grayB <= (mx == mn);
      for (int c = 0; c < CHANNELS; c++)
        dB[c] <= $signed({1'b0, pixA[c], 1'b0}) - $signed({1'b0, sum_w});
    end
  end

  // stage C: pull product and halving, offset magnitudes
  logic signed [IW-1:0] factor;
  logic signed [HW-1:0] prod [3];
  logic signed [HW-1:0] half [3];
  logic signed [HW-1:0] dx   [3];
  logic signed [HW-1:0] fx;
  logic signed [9:0]    dabs [3];
  logic [2:0][7:0]      pixC;
  logic [8:0]           sumC;
  logic [7:0]           denC, spanC;
  logic [2:0]           dnegC;
  logic [2:0][8:0]      dmagC;
  logic [2:0][HW-1:0]   halfC;
  logic                 grayC;

  always_comb begin
    factor = ONE_I + inc_q;
    fx     = factor;
    for (int c = 0; c < CHANNELS; c++) begin
      dx[c]   = dB[c];
      prod[c] = dx[c] * fx;
      half[c] = (prod[c] + $signed({{(HW-1){1'b0}}, prod[c][HW-1]})) >>> 1;
      dabs[c] = dB[c][9] ? -dB[c] : dB[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vC <= 1'b0;
    else if (rdyC) vC <= vB;
  end
  always_ff @(posedge clk) begin
    if (rdyC && vB) begin
      pixC  <= pixB;
      sumC  <= sumB;
      denC  <= denB;
      spanC <= spanB;
      grayC <= grayB;
      for (int c = 0; c < CHANNELS; c++) begin
        dnegC[c] <= dB[c][9];
        dmagC[c] <= dabs[c][8:0];
        halfC[c] <= half[c];
      end
    end
  end

  // saturation divider: span * 2^F / den
  logic [0:0][SNW-1:0] d1_num;
  logic [0:0][7:0]     d1_den;
  logic [0:0][SQ-1:0]  d1_quo;
  logic [S1W-1:0]      d1_side_in, d1_side_out;

  assign d1_num[0]  = {spanC, {FRAC_BITS{1'b0}}};
  assign d1_den[0]  = denC;
  assign d1_side_in = {grayC, pixC, sumC, dnegC, dmagC, halfC};

  rsa_div_pipe #(.LANES(1), .NW(SNW), .DW(8), .QB(SQ), .SW(S1W)) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vC),
    .in_ready  (d1_in_ready),
    .in_num    (d1_num),
    .in_den    (d1_den),
    .in_side   (d1_side_in),
    .out_valid (d1_out_valid),
    .out_ready (rdyD),
    .out_quo   (d1_quo),
    .out_side  (d1_side_out)
  );

  // stage D: pick the push divisor
  logic               gray1;
  logic [2:0][7:0]    pix1;
  logic [8:0]         sum1;
  logic [2:0]         dneg1;
  logic [2:0][8:0]    dmag1;
  logic [2:0][HW-1:0] half1;
  logic signed [IW:0] sat_x, inc_x, one_x;
  logic signed [IW-1:0] a_alt;
  logic [SQ-1:0]      a_w;
  logic [SQ-1:0]      aD;
  logic               pushD, grayD;
  logic [2:0][7:0]    pixD;
  logic [8:0]         sumD;
  logic [2:0]         dnegD;
  logic [2:0][8:0]    dmagD;
  logic [2:0][HW-1:0] halfD;

  always_comb begin
    {gray1, pix1, sum1, dneg1, dmag1, half1} = d1_side_out;
    sat_x = $signed({{(IW-SQ+1){1'b0}}, d1_quo[0]});
    inc_x = inc_q;
    one_x = ONE_I;
    a_alt = ONE_I - inc_q;
    a_w   = (sat_x + inc_x >= one_x) ? d1_quo[0] : a_alt[SQ-1:0];
    if (a_w == '0) a_w = SQ'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) vD <= 1'b0;
    else if (rdyD) vD <= d1_out_valid;
  end
  always_ff @(posedge clk) begin
    if (rdyD && d1_out_valid) begin
      aD    <= a_w;
      pushD <= !inc_q[IW-1];
      grayD <= gray1;
      pixD  <= pix1;
      sumD  <= sum1;
      dnegD <= dneg1;
      dmagD <= dmag1;
      halfD <= half1;
    end
  end

  // stage E: flag quotients that would clip anyway
  logic [SQ-1:0]      aE;
  logic [2:0]         ovfE;
  logic               pushE, grayE;
  logic [2:0][7:0]    pixE;
  logic [8:0]         sumE;
  logic [2:0]         dnegE;
  logic [2:0][8:0]    dmagE;
  logic [2:0][HW-1:0] halfE;

  always_ff @(posedge clk) begin
    if (rst) vE <= 1'b0;
    else if (rdyE) vE <= vD;
  end
  always_ff @(posedge clk) begin
    if (rdyE && vD) begin
      for (int c = 0; c < CHANNELS; c++)
        ovfE[c] <= ({2'b00, dmagD[c], {(FRAC_BITS-1){1'b0}}} >= {aD, 9'b0});
      aE    <= aD;
      pushE <= pushD;
      grayE <= grayD;
      pixE  <= pixD;
      sumE  <= sumD;
      dnegE <= dnegD;
      dmagE <= dmagD;
      halfE <= halfD;
    end
  end

  // push divider: |d| * 2^(2F-1) / a
  logic [2:0][PNW-1:0] d2_num;
  logic [2:0][SQ-1:0]  d2_den;
  logic [2:0][PQ-1:0]  d2_quo;
  logic [S2W-1:0]      d2_side_in, d2_side_out;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      d2_num[c] = {dmagE[c], {(2*FRAC_BITS-1){1'b0}}};
      d2_den[c] = aE;
    end
  end
  assign d2_side_in = {grayE, pixE, sumE, dnegE, ovfE, pushE, halfE};

  rsa_div_pipe #(.LANES(3), .NW(PNW), .DW(SQ), .QB(PQ), .SW(S2W)) u_push_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vE),
    .in_ready  (d2_in_ready),
    .in_num    (d2_num),
    .in_den    (d2_den),
    .in_side   (d2_side_in),
    .out_valid (d2_out_valid),
    .out_ready (rdyF),
    .out_quo   (d2_quo),
    .out_side  (d2_side_out)
  );

  // stage F: add lightness, clip to a byte, pass gray pixels
  logic               gray2, push2;
  logic [2:0][7:0]    pix2;
  logic [8:0]         sum2;
  logic [2:0]         dneg2, ovf2;
  logic [2:0][HW-1:0] half2;
  logic signed [VW-1:0] lv, qv, hv, v;
  logic signed [HW-1:0] hs;
  logic [2:0][7:0]    res;
  logic [2:0][7:0]    pixF;

  always_comb begin
    {gray2, pix2, sum2, dneg2, ovf2, push2, half2} = d2_side_out;
    lv = $signed(VW'({sum2, {(FRAC_BITS-1){1'b0}}}));
    for (int c = 0; c < CHANNELS; c++) begin
      qv = $signed(VW'(d2_quo[c]));
      hs = half2[c];
      hv = hs;
      if (push2) v = dneg2[c] ? (lv - qv) : (lv + qv);
      else       v = lv + hv;
      if (gray2)                  res[c] = pix2[c];
      else if (push2 && ovf2[c])  res[c] = dneg2[c] ? BYTE_MIN : BYTE_MAX;
      else if (v[VW-1])           res[c] = BYTE_MIN;
      else if (|v[VW-2:FRAC_BITS+8]) res[c] = BYTE_MAX;
      else                        res[c] = v[FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vF <= 1'b0;
    else if (rdyF) vF <= d2_out_valid;
  end
  always_ff @(posedge clk) begin
    if (rdyF && d2_out_valid) pixF <= res;
  end

  assign m_axis_tdata  = pixF;
  assign m_axis_tvalid = vF;

`ifndef SYNTHESIS
  // a register write holds off pixels while the increment is rebuilt
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == CFG_SAT_LEVEL || cfg_index == CFG_INC_SCALE))
    |=> !s_axis_tready)
    else $error("pixel accepted right after a register write");

  a_busy_no_input: assert property (@(posedge clk) disable iff (rst)
    inc_busy |-> (!s_axis_tready && !cfg_ready))
    else $error("port ready while the increment divider runs");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word valid after reset");
`endif

endmodule

// ===== hdl/rsa_inc_div.sv =====
module rsa_inc_div import rsa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NW = FRAC_BITS + 8,
  localparam int IW = FRAC_BITS + 9,
  localparam int CW = $clog2(NW + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0]           level,
  input  logic [7:0]           scale,
  output logic                 busy,
  output logic signed [IW-1:0] inc_q
);

  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [NW-1:0] quo_next;
  logic [7:0]    rem;
  logic [7:0]    rem_next;
  logic [7:0]    div;
  logic [7:0]    mag;
  logic [8:0]    t;
  logic [8:0]    diff;
  logic          neg;
  logic          ge;
  logic [CW-1:0] cnt;

  // form the divisor and the offset magnitude
  always_comb begin
    div = (scale == 8'd0) ? 8'd1 : scale;
    mag = (level >= LEVEL_NEUTRAL) ? (level - LEVEL_NEUTRAL) : (LEVEL_NEUTRAL - level);
  end

  // one restoring step per cycle
  always_comb begin
    t        = {rem, num[NW-1]};
    diff     = t - {1'b0, div};
    ge       = (t >= {1'b0, div});
    rem_next = ge ? diff[7:0] : t[7:0];
    quo_next = {quo[NW-2:0], ge};
  end

  // control: start, count down, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      inc_q <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy  <= 1'b0;
        inc_q <= neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= (level < LEVEL_NEUTRAL);
      num <= {mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

// ===== hdl/rsa_div_pipe.sv =====
module rsa_div_pipe import rsa_pkg::*; #(
  parameter int LANES = 1,
  parameter int NW    = 24,
  parameter int DW    = 8,
  parameter int QB    = 17,
  parameter int SW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [LANES-1:0][DW-1:0]   in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LANES-1:0][QB-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  logic                     vld    [QB+1];
  logic                     rdy    [QB+2];
  logic [LANES-1:0][NW-1:0] num_s  [QB+1];
  logic [LANES-1:0][DW-1:0] den_s  [QB+1];
  logic [LANES-1:0][DW-1:0] rem_s  [QB+1];
  logic [LANES-1:0][QB-1:0] quo_s  [QB+1];
  logic [SW-1:0]            side_s [QB+1];

  // a stage moves when it is empty or its successor takes its word
  assign rdy[QB+1] = out_ready;
  for (genvar s = 0; s <= QB; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign in_ready = rdy[0];

  // load stage: upper numerator bits form the first remainder
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (rdy[0]) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin : p_load
    logic [NW-1:0] hi;
    if (rdy[0] && in_valid) begin
      for (int l = 0; l < LANES; l++) begin
        hi          = in_num[l] >> QB;
        rem_s[0][l] <= hi[DW-1:0];
      end
      num_s[0]  <= in_num;
      den_s[0]  <= in_den;
      quo_s[0]  <= '0;
      side_s[0] <= in_side;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_n;
    logic [LANES-1:0][QB-1:0] quo_n;

    always_comb begin
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        t        = {rem_s[s-1][l], num_s[s-1][l][QB-s]};
        diff     = t - {1'b0, den_s[s-1][l]};
        ge       = (t >= {1'b0, den_s[s-1][l]});
        rem_n[l] = ge ? diff[DW-1:0] : t[DW-1:0];
        quo_n[l] = quo_s[s-1][l];
        quo_n[l][QB-s] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (rdy[s]) vld[s] <= vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld[s-1]) begin
        num_s[s]  <= num_s[s-1];
        den_s[s]  <= den_s[s-1];
        rem_s[s]  <= rem_n;
        quo_s[s]  <= quo_n;
        side_s[s] <= side_s[s-1];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_quo   = quo_s[QB];
  assign out_side  = side_s[QB];

endmodule
